// ----- sv/rfnr_pkg.sv -----
// shared constants, codes and the dbm to linear power table for the fingerprint locator
package rfnr_pkg;

    // default sizes of the stores
    localparam int MAX_ROOMS_DEF   = 64;
    localparam int MAX_ROUTERS_DEF = 16;
    localparam int MAX_USERS_DEF   = 16;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SEAL  = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    // configuration register indexes
    localparam logic CFG_ROOMS   = 1'b0;
    localparam logic CFG_ROUTERS = 1'b1;

    // field and datapath widths
    localparam int PW    = 48;   // linear power
    localparam int HW    = 24;   // half of a power word, one multiplier operand
    localparam int QW    = 17;   // normalized value, up to 2^16
    localparam int DISTW = 22;   // reported distance
    localparam int SQW   = 2 * PW;
    localparam int TABN  = 148;

    localparam logic signed [7:0] ABSENT_DBM = -8'sd128;
    localparam logic [DISTW-1:0]  START_DIST = 22'd3000000;

    typedef logic [PW-1:0] t_pow;
    typedef t_pow          t_pow_tab [TABN];

    function automatic logic [63:0] tenth_pow(input int k);
        logic [63:0] m;
        case (k)
            0:       m = 64'd1000000000000000000;
            1:       m = 64'd794328234724281502;
            2:       m = 64'd630957344480193249;
            3:       m = 64'd501187233627272285;
            4:       m = 64'd398107170553497251;
            5:       m = 64'd316227766016837933;
            6:       m = 64'd251188643150958011;
            7:       m = 64'd199526231496887960;
            8:       m = 64'd158489319246111349;
            default: m = 64'd125892541179416721;
        endcase
        return m;
    endfunction

    // round(2^47 * 10^(-e/10)), built exactly in integer arithmetic
    function automatic t_pow_tab build_pow_tab();
        t_pow_tab    tab;
        logic [127:0] x;
        int          n;
        for (int e = 0; e < TABN; e++) begin
            n = 18 + e / 10;
            x = 128'(tenth_pow(e % 10)) << 47;
            for (int k = 0; k < n - 1; k++) begin
                x = x / 128'd10;
            end
            x = (x + 128'd5) / 128'd10;
            tab[e] = x[PW-1:0];
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = build_pow_tab();

    function automatic t_pow dbm_power(input logic signed [7:0] d);
        t_pow p;
        if (d < -8'sd127) begin
            p = '0;
        end else if (d > 8'sd20) begin
            p = POW_TAB[0];
        end else begin
            p = POW_TAB[8'(9'sd20 - 9'(d))];
        end
        return p;
    endfunction

endpackage

// ----- sv/rssi_fingerprint_nearest_room_top.sv -----
// signal-strength fingerprint locator: stores, normalizer and nearest-room search
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tuser op, tdata room,user,router,dbm
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tuser status, tdata room,distance
//  cfg       in   i_cfg_wr_en                        i_cfg_addr, i_cfg_wdata
//
// one request at a time; a small sequencer drives one 24x24 multiplier, one square-root
//   step and one divide step, each used once per cycle
// load and set write one store entry; a first set to a user clears all its entries first
// seal: per router, reads and squares the entry; then a 50-step root; then per router, reads,
//   divides by 17 steps and writes back
// query: the seal steps on the user values, kept apart, then the distance walk over the rooms
// synchronous active-low reset clears control state only; the reference store is not cleared
// a finished result waits in the output register; the next request is taken meanwhile

module rssi_fingerprint_nearest_room_top #(
    parameter int MAX_ROOMS   = rfnr_pkg::MAX_ROOMS_DEF,
    parameter int MAX_ROUTERS = rfnr_pkg::MAX_ROUTERS_DEF,
    parameter int MAX_USERS   = rfnr_pkg::MAX_USERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // room_index[5:0], user_index[9:6],
                                          // router_index[13:10], dbm_value[21:14]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // best_room[5:0], best_distance[27:6]
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    // configuration writes
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);

    localparam int PW    = rfnr_pkg::PW;
    localparam int HW    = rfnr_pkg::HW;
    localparam int QW    = rfnr_pkg::QW;
    localparam int DISTW = rfnr_pkg::DISTW;

    localparam int RIW   = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;
    localparam int RCW   = $clog2(MAX_ROUTERS + 1);
    localparam int RMW   = $clog2(MAX_ROOMS + 1);
    localparam int UIW   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int AW    = (MAX_ROOMS * MAX_ROUTERS > 1) ? $clog2(MAX_ROOMS * MAX_ROUTERS) : 1;
    localparam int UAW   = (MAX_USERS * MAX_ROUTERS > 1) ? $clog2(MAX_USERS * MAX_ROUTERS) : 1;
    localparam int SUMR  = rfnr_pkg::SQW + RIW;
    localparam int SUMW  = ((SUMR + 1) / 2) * 2;
    localparam int ROOTW = SUMW / 2;
    localparam int REMW  = ROOTW + 3;
    localparam int DVW   = ROOTW + 2;
    localparam int DW    = PW + RIW;
    localparam int CW    = $clog2(((ROOTW > QW) ? ROOTW : QW) + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_WREF = 5'd1;
    localparam logic [4:0] S_CLR  = 5'd2;
    localparam logic [4:0] S_SETU = 5'd3;
    localparam logic [4:0] S_NRD  = 5'd4;
    localparam logic [4:0] S_NLD  = 5'd5;
    localparam logic [4:0] S_NMUL = 5'd6;
    localparam logic [4:0] S_NACC = 5'd7;
    localparam logic [4:0] S_SQRT = 5'd8;
    localparam logic [4:0] S_DRD  = 5'd9;
    localparam logic [4:0] S_DLD  = 5'd10;
    localparam logic [4:0] S_DIV  = 5'd11;
    localparam logic [4:0] S_DWR  = 5'd12;
    localparam logic [4:0] S_QRD  = 5'd13;
    localparam logic [4:0] S_QACC = 5'd14;
    localparam logic [4:0] S_QCMP = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    // configuration
    logic [6:0] r_rooms_cfg;
    logic [4:0] r_routers_cfg;

    // sequencer and request fields
    logic [4:0]  r_state, n_state;
    logic [1:0]  r_op;
    logic [1:0]  r_status;
    logic [3:0]  r_router;
    logic signed [7:0] r_dbm;
    logic [UIW-1:0] r_user;
    logic [AW-1:0]  r_base;
    logic [UAW-1:0] r_ubase;
    logic [RCW-1:0] r_idx;
    logic [RMW-1:0] r_room;
    logic [1:0]  r_part;
    logic [CW-1:0] r_cnt;
    logic [MAX_USERS-1:0] r_present;

    // datapath
    logic [PW-1:0]    r_val;
    logic [2*HW-1:0]  r_prod;
    logic [SUMW-1:0]  r_sum;
    logic [REMW-1:0]  r_rem;
    logic [ROOTW-1:0] r_root;
    logic [DVW-1:0]   r_div;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_d;
    logic [DISTW-1:0] r_best;
    logic [RMW-1:0]   r_best_room;
    logic             r_found;

    // memories
    logic [PW-1:0] r_ref_mem [MAX_ROOMS * MAX_ROUTERS];
    logic [7:0]    r_user_mem [MAX_USERS * MAX_ROUTERS];
    logic [QW-1:0] r_q_mem [MAX_ROUTERS];
    logic [PW-1:0] r_ref_rd;
    logic [7:0]    r_user_rd;
    logic [QW-1:0] r_q_rd;

    // result register
    logic             r_m_vld;
    logic [1:0]       r_o_status;
    logic [5:0]       r_o_room;
    logic [DISTW-1:0] r_o_dist;

    // request fields
    logic [1:0]        s_op;
    logic [5:0]        s_room;
    logic [3:0]        s_user;
    logic [3:0]        s_router;
    logic signed [7:0] s_dbm;
    logic              s_acc;

    assign s_op     = i_s_axis_tuser;
    assign s_room   = i_s_axis_tdata[5:0];
    assign s_user   = i_s_axis_tdata[9:6];
    assign s_router = i_s_axis_tdata[13:10];
    assign s_dbm    = i_s_axis_tdata[21:14];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // clamped sizes
    logic [RCW-1:0] nr;
    logic [RMW-1:0] nrooms;
    logic           idx_last;
    logic           src_user;

    always_comb begin
        if (r_routers_cfg == 5'd0) begin
            nr = RCW'(1);
        end else if (int'(r_routers_cfg) > MAX_ROUTERS) begin
            nr = RCW'(MAX_ROUTERS);
        end else begin
            nr = RCW'(r_routers_cfg);
        end
        if (int'(r_rooms_cfg) > MAX_ROOMS) begin
            nrooms = RMW'(MAX_ROOMS);
        end else begin
            nrooms = RMW'(r_rooms_cfg);
        end
    end

    assign idx_last = (r_idx == nr - RCW'(1));
    assign src_user = (r_op == rfnr_pkg::OP_QUERY);

    // request checks
    logic room_bad, user_bad, router_bad;
    logic [UIW-1:0] s_user_ix;

    assign room_bad   = int'(s_room) >= MAX_ROOMS;
    assign user_bad   = int'(s_user) >= MAX_USERS;
    assign router_bad = int'(s_router) >= int'(nr);
    assign s_user_ix  = UIW'(s_user);

    // one table port: the load value or the user value being normalized
    logic [PW-1:0] pow_out;
    logic [PW-1:0] ld_val;

    assign pow_out = rfnr_pkg::dbm_power((r_state == S_WREF) ? r_dbm : signed'(r_user_rd));
    assign ld_val  = src_user ? pow_out : r_ref_rd;

    // memory addresses
    logic [AW-1:0]  ref_raddr, ref_waddr;
    logic [UAW-1:0] user_addr;
    logic [QW-1:0]  norm_out;
    logic           ref_we, user_we, q_we;
    logic [PW-1:0]  ref_wdata;
    logic [7:0]     user_wdata;

    assign ref_raddr  = r_base + AW'(r_idx);
    assign ref_waddr  = (r_state == S_WREF) ? (r_base + AW'(r_router)) : ref_raddr;
    assign norm_out   = (r_root == '0) ? '0 : r_quo;
    assign ref_we     = (r_state == S_WREF) || ((r_state == S_DWR) && !src_user);
    assign ref_wdata  = (r_state == S_WREF) ? pow_out : PW'(norm_out);
    assign user_addr  = (r_state == S_SETU) ? (r_ubase + UAW'(r_router))
                                            : (r_ubase + UAW'(r_idx));
    assign user_we    = (r_state == S_CLR) || (r_state == S_SETU);
    assign user_wdata = (r_state == S_CLR) ? rfnr_pkg::ABSENT_DBM : r_dbm;
    assign q_we       = (r_state == S_DWR) && src_user;

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            r_ref_mem[ref_waddr] <= ref_wdata;
        end
        r_ref_rd <= r_ref_mem[ref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (user_we) begin
            r_user_mem[user_addr] <= user_wdata;
        end
        r_user_rd <= r_user_mem[user_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[r_idx[RIW-1:0]] <= norm_out;
        end
        r_q_rd <= r_q_mem[r_idx[RIW-1:0]];
    end

    // shared multiplier: halves of the power word, three partial products per square
    logic [HW-1:0]   mul_a, mul_b;
    logic [SUMW-1:0] acc_add;

    assign mul_a = (r_part == 2'd2) ? r_val[PW-1:HW] : r_val[HW-1:0];
    assign mul_b = (r_part == 2'd0) ? r_val[HW-1:0] : r_val[PW-1:HW];

    always_comb begin
        case (r_part)
            2'd0:    acc_add = SUMW'(r_prod);
            2'd1:    acc_add = SUMW'(r_prod) << (HW + 1);
            default: acc_add = SUMW'(r_prod) << (2 * HW);
        endcase
    end

    // square-root step, two sum bits per cycle
    logic [REMW-1:0] sq_sh, sq_trial;
    logic            sq_ge;

    assign sq_sh    = {r_rem[REMW-3:0], r_sum[SUMW-1 -: 2]};
    assign sq_trial = REMW'({r_root, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    // divide step, one quotient bit per cycle
    logic [DVW-1:0] dv_t;
    logic           dv_ge;

    assign dv_t  = (r_cnt == '0) ? r_div : (r_div << 1);
    assign dv_ge = (dv_t >= DVW'(r_root));

    // distance term
    logic [PW-1:0] q_ext, adiff;

    assign q_ext = PW'(r_q_rd);
    assign adiff = (q_ext > r_ref_rd) ? (q_ext - r_ref_rd) : (r_ref_rd - q_ext);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_op)
                        rfnr_pkg::OP_LOAD:
                            n_state = (room_bad || router_bad) ? S_DONE : S_WREF;
                        rfnr_pkg::OP_SEAL:
                            n_state = room_bad ? S_DONE : S_NRD;
                        rfnr_pkg::OP_SET: begin
                            if (user_bad || router_bad) begin
                                n_state = S_DONE;
                            end else if (r_present[s_user_ix]) begin
                                n_state = S_SETU;
                            end else begin
                                n_state = S_CLR;
                            end
                        end
                        default: begin
                            if (user_bad || !r_present[s_user_ix] || nrooms == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_NRD;
                            end
                        end
                    endcase
                end
            end
            S_WREF:  n_state = S_DONE;
            S_CLR:   n_state = (int'(r_idx) == MAX_ROUTERS - 1) ? S_SETU : S_CLR;
            S_SETU:  n_state = S_DONE;
            S_NRD:   n_state = S_NLD;
            S_NLD:   n_state = S_NMUL;
            S_NMUL:  n_state = S_NACC;
            S_NACC: begin
                if (r_part != 2'd2) begin
                    n_state = S_NMUL;
                end else begin
                    n_state = idx_last ? S_SQRT : S_NRD;
                end
            end
            S_SQRT:  n_state = (int'(r_cnt) == ROOTW - 1) ? S_DRD : S_SQRT;
            S_DRD:   n_state = S_DLD;
            S_DLD:   n_state = S_DIV;
            S_DIV:   n_state = (int'(r_cnt) == QW - 1) ? S_DWR : S_DIV;
            S_DWR: begin
                if (!idx_last) begin
                    n_state = S_DRD;
                end else begin
                    n_state = src_user ? S_QRD : S_DONE;
                end
            end
            S_QRD:   n_state = S_QACC;
            S_QACC:  n_state = idx_last ? S_QCMP : S_QRD;
            S_QCMP:  n_state = (r_room == nrooms - RMW'(1)) ? S_DONE : S_QRD;
            S_DONE:  n_state = (!r_m_vld || i_m_axis_tready) ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rooms_cfg   <= 7'd0;
            r_routers_cfg <= 5'd16;
            r_present     <= '0;
            r_m_vld       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    rfnr_pkg::CFG_ROOMS:   r_rooms_cfg   <= i_cfg_wdata;
                    rfnr_pkg::CFG_ROUTERS: r_routers_cfg <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end

            // a result loaded in the done state refills the register instead
            if (r_m_vld && i_m_axis_tready && (r_state != S_DONE)) begin
                r_m_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_op     <= s_op;
                        r_router <= s_router;
                        r_dbm    <= s_dbm;
                        r_user   <= s_user_ix;
                        r_base   <= AW'(int'(s_room) * MAX_ROUTERS);
                        r_ubase  <= UAW'(int'(s_user) * MAX_ROUTERS);
                        r_idx    <= '0;
                        r_part   <= 2'd0;
                        r_sum    <= '0;
                        r_status <= rfnr_pkg::ST_OK;
                        r_found  <= 1'b0;
                        case (s_op)
                            rfnr_pkg::OP_LOAD, rfnr_pkg::OP_SET: begin
                                if (room_bad && s_op == rfnr_pkg::OP_LOAD) begin
                                    r_status <= rfnr_pkg::ST_RANGE;
                                end
                                if (user_bad && s_op == rfnr_pkg::OP_SET) begin
                                    r_status <= rfnr_pkg::ST_RANGE;
                                end
                                if (router_bad) begin
                                    r_status <= rfnr_pkg::ST_RANGE;
                                end
                            end
                            rfnr_pkg::OP_SEAL: begin
                                if (room_bad) begin
                                    r_status <= rfnr_pkg::ST_RANGE;
                                end
                            end
                            default: begin
                                if (user_bad) begin
                                    r_status <= rfnr_pkg::ST_RANGE;
                                end else if (!r_present[s_user_ix] || nrooms == '0) begin
                                    r_status <= rfnr_pkg::ST_NONE;
                                end
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + RCW'(1);
                end
                S_SETU: begin
                    r_present[r_user] <= 1'b1;
                end
                S_NLD: begin
                    r_val  <= ld_val;
                    r_part <= 2'd0;
                end
                S_NMUL: begin
                    r_prod <= mul_a * mul_b;
                end
                S_NACC: begin
                    r_sum <= r_sum + acc_add;
                    if (r_part != 2'd2) begin
                        r_part <= r_part + 2'd1;
                    end else if (idx_last) begin
                        r_cnt  <= '0;
                        r_rem  <= '0;
                        r_root <= '0;
                    end else begin
                        r_idx <= r_idx + RCW'(1);
                    end
                end
                S_SQRT: begin
                    r_rem  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                    r_root <= {r_root[ROOTW-2:0], sq_ge};
                    r_sum  <= r_sum << 2;
                    r_cnt  <= r_cnt + CW'(1);
                    r_idx  <= '0;
                end
                S_DLD: begin
                    r_div <= DVW'(ld_val);
                    r_quo <= '0;
                    r_cnt <= '0;
                end
                S_DIV: begin
                    r_div <= dv_ge ? (dv_t - DVW'(r_root)) : dv_t;
                    r_quo <= {r_quo[QW-2:0], dv_ge};
                    r_cnt <= r_cnt + CW'(1);
                end
                S_DWR: begin
                    if (!idx_last) begin
                        r_idx <= r_idx + RCW'(1);
                    end else begin
                        // start of the room walk
                        r_idx  <= '0;
                        r_base <= '0;
                        r_room <= '0;
                        r_d    <= '0;
                        r_best <= rfnr_pkg::START_DIST;
                    end
                end
                S_QACC: begin
                    r_d <= r_d + DW'(adiff);
                    if (!idx_last) begin
                        r_idx <= r_idx + RCW'(1);
                    end
                end
                S_QCMP: begin
                    // ties go to the later room
                    if (r_d <= DW'(r_best)) begin
                        r_best      <= DISTW'(r_d);
                        r_best_room <= r_room;
                        r_found     <= 1'b1;
                    end
                    r_room <= r_room + RMW'(1);
                    r_base <= r_base + AW'(MAX_ROUTERS);
                    r_idx  <= '0;
                    r_d    <= '0;
                end
                S_DONE: begin
                    if (!r_m_vld || i_m_axis_tready) begin
                        r_m_vld <= 1'b1;
                        if (r_op == rfnr_pkg::OP_QUERY && r_status == rfnr_pkg::ST_OK) begin
                            if (r_found) begin
                                r_o_status <= rfnr_pkg::ST_OK;
                                r_o_room   <= 6'(r_best_room);
                                r_o_dist   <= r_best;
                            end else begin
                                r_o_status <= rfnr_pkg::ST_NONE;
                                r_o_room   <= '0;
                                r_o_dist   <= '0;
                            end
                        end else begin
                            r_o_status <= r_status;
                            r_o_room   <= '0;
                            r_o_dist   <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tdata  = {4'd0, r_o_dist, r_o_room};
    assign o_m_axis_tuser  = r_o_status;

`ifndef SYNTH
    // results whose status is not OK carry no room or distance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != rfnr_pkg::ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("error result carries payload");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == rfnr_pkg::ST_OK) ||
                            (o_m_axis_tuser == rfnr_pkg::ST_RANGE) ||
                            (o_m_axis_tuser == rfnr_pkg::ST_NONE))
        else $error("bad status code");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[27:6] <= rfnr_pkg::START_DIST))
        else $error("distance above start bound");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle after a request");
`endif

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the fingerprint locator: directed table, then random phases
`timescale 1ns / 100ps

module tb_top;

    localparam int ROOMS    = rfnr_pkg::MAX_ROOMS_DEF;
    localparam int ROUTERS  = rfnr_pkg::MAX_ROUTERS_DEF;
    localparam int USERS    = rfnr_pkg::MAX_USERS_DEF;
    localparam int WDOG_MAX = 20000;   // well above the longest query
    localparam int ITEMS    = 1050;

    // 10^(-k/10) scaled by 10^18
    localparam logic [63:0] TENTHS [10] = '{
        64'd1000000000000000000, 64'd794328234724281502, 64'd630957344480193249,
        64'd501187233627272285, 64'd398107170553497251, 64'd316227766016837933,
        64'd251188643150958011, 64'd199526231496887960, 64'd158489319246111349,
        64'd125892541179416721
    };

    typedef struct packed {
        logic [1:0]                 status;
        logic [5:0]                 room;
        logic [rfnr_pkg::DISTW-1:0] distance;
    } t_locate_res;

    typedef struct {
        bit          is_cfg;
        logic        addr;
        logic [6:0]  value;
        logic [1:0]  op;
        int          room;
        int          user;
        int          router;
        int          dbm;
        bit          typed;
        t_locate_res res;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;

    rssi_fingerprint_nearest_room_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [rfnr_pkg::PW-1:0] power_table [rfnr_pkg::TABN];
    logic [63:0]       room_vec [ROOMS*ROUTERS];
    bit                room_written [ROOMS*ROUTERS];
    logic signed [7:0] user_dbm [USERS*ROUTERS];
    bit                user_known [USERS];
    logic [6:0]        rooms_reg = 7'd0;
    logic [4:0]        routers_reg = 5'd16;

    t_locate_res expected_results [$];
    int          fails = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          stall_left = 0;

    // exact 2^47 * 10^(-e/10), rounded
    function automatic void build_power_table();
        logic [127:0] div;
        logic [127:0] x;
        for (int e = 0; e < rfnr_pkg::TABN; e++) begin
            div = 128'd1;
            for (int k = 0; k < 17 + e / 10; k++) begin
                div = div * 128'd10;
            end
            x = (128'(TENTHS[e % 10]) << 47) / div;
            x = (x + 128'd5) / 128'd10;
            power_table[e] = x[rfnr_pkg::PW-1:0];
        end
    endfunction

    function automatic logic [63:0] to_power(logic signed [7:0] d);
        if (d == rfnr_pkg::ABSENT_DBM) begin
            return 64'd0;
        end
        if (d > 8'sd20) begin
            return 64'(power_table[0]);
        end
        return 64'(power_table[20 - int'(d)]);
    endfunction

    function automatic int active_routers();
        if (routers_reg == 5'd0) begin
            return 1;
        end
        return (routers_reg > ROUTERS) ? ROUTERS : int'(routers_reg);
    endfunction

    // l2 normalize into q1.16 with floor integer square root
    function automatic void normalize_vec(ref logic [63:0] v [ROUTERS], input int n);
        logic [127:0] sum_sq;
        logic [63:0]  root;
        logic [63:0]  t;
        sum_sq = '0;
        root = '0;
        for (int i = 0; i < n; i++) begin
            sum_sq += 128'(v[i]) * 128'(v[i]);
        end
        for (int b = 50; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if (128'(t) * 128'(t) <= sum_sq) begin
                root = t;
            end
        end
        for (int i = 0; i < n; i++) begin
            v[i] = (root == 0) ? 64'd0 : (v[i] << 16) / root;
        end
    endfunction

    function automatic t_locate_res predict_step(logic [1:0] op, int room, int user,
                                                 int router, logic signed [7:0] dbm);
        t_locate_res  r;
        int           nr;
        int           nrooms;
        logic [63:0]  vec [ROUTERS];
        logic [63:0]  best;
        logic [63:0]  d;
        bit           found;
        r = '0;
        nr = active_routers();
        case (op)
            rfnr_pkg::OP_LOAD: begin
                if (router >= nr) begin
                    r.status = rfnr_pkg::ST_RANGE;
                end else begin
                    room_vec[room*ROUTERS + router] = to_power(dbm);
                    room_written[room*ROUTERS + router] = 1'b1;
                end
            end
            rfnr_pkg::OP_SEAL: begin
                for (int i = 0; i < ROUTERS; i++) vec[i] = room_vec[room*ROUTERS + i];
                normalize_vec(vec, nr);
                for (int i = 0; i < nr; i++) room_vec[room*ROUTERS + i] = vec[i];
            end
            rfnr_pkg::OP_SET: begin
                if (router >= nr) begin
                    r.status = rfnr_pkg::ST_RANGE;
                end else begin
                    if (!user_known[user]) begin
                        for (int i = 0; i < ROUTERS; i++) begin
                            user_dbm[user*ROUTERS + i] = rfnr_pkg::ABSENT_DBM;
                        end
                        user_known[user] = 1'b1;
                    end
                    user_dbm[user*ROUTERS + router] = dbm;
                end
            end
            default: begin
                nrooms = (rooms_reg > ROOMS) ? ROOMS : int'(rooms_reg);
                if (!user_known[user] || nrooms == 0) begin
                    r.status = rfnr_pkg::ST_NONE;
                end else begin
                    for (int i = 0; i < ROUTERS; i++) begin
                        vec[i] = (i < nr) ? to_power(user_dbm[user*ROUTERS + i]) : 64'd0;
                    end
                    normalize_vec(vec, nr);
                    best = 64'(rfnr_pkg::START_DIST);
                    found = 1'b0;
                    for (int rm = 0; rm < nrooms; rm++) begin
                        d = 0;
                        for (int i = 0; i < nr; i++) begin
                            d += (vec[i] > room_vec[rm*ROUTERS + i])
                                ? vec[i] - room_vec[rm*ROUTERS + i]
                                : room_vec[rm*ROUTERS + i] - vec[i];
                        end
                        if (d <= best) begin
                            best = d;
                            r.room = 6'(rm);
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        r.distance = (best > 64'h3FFFFF) ? '1 : rfnr_pkg::DISTW'(best);
                    end else begin
                        r.status = rfnr_pkg::ST_NONE;
                        r.room = '0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // true when the first nr entries of a room hold data
    function automatic bit room_ready(int room);
        for (int i = 0; i < active_routers(); i++) begin
            if (!room_written[room*ROUTERS + i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // hand one request to the block; tvalid stays high after acceptance
    task automatic send_request(logic [1:0] op, int room, int user, int router, int dbm,
                                bit typed = 1'b0, t_locate_res typed_res = '0);
        t_locate_res r;
        int          gap;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {2'b00, 8'(dbm), 4'(router), 4'(user), 6'(room)};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = predict_step(op, room, user, router, 8'(dbm));
        expected_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic addr, logic [6:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (addr == rfnr_pkg::CFG_ROOMS) begin
            rooms_reg = value;
        end else begin
            routers_reg = value[4:0];
        end
    endtask

    // one configuration with its fill loads and a burst of mixed requests
    task automatic run_phase(int phase);
        int rooms_full;
        int nr;
        int n_req;
        int pick;
        int room;
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        if (phase % 4 == 1) begin
            // single router lets every room be filled cheaply
            write_reg(rfnr_pkg::CFG_ROUTERS, 7'($urandom_range(0, 1)));
            rooms_full = ROOMS;
            case ($urandom_range(0, 2))
                0:       write_reg(rfnr_pkg::CFG_ROOMS, 7'd127);
                1:       write_reg(rfnr_pkg::CFG_ROOMS, 7'd64);
                default: write_reg(rfnr_pkg::CFG_ROOMS, 7'($urandom_range(0, 64)));
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0:       write_reg(rfnr_pkg::CFG_ROUTERS, 7'd31);
                1:       write_reg(rfnr_pkg::CFG_ROUTERS, 7'd16);
                2:       write_reg(rfnr_pkg::CFG_ROUTERS, 7'd1);
                default: write_reg(rfnr_pkg::CFG_ROUTERS, 7'($urandom_range(1, 16)));
            endcase
            rooms_full = $urandom_range(1, 8);
            write_reg(rfnr_pkg::CFG_ROOMS, 7'($urandom_range(0, rooms_full)));
        end
        nr = active_routers();
        for (int rm = 0; rm < rooms_full; rm++) begin
            for (int i = 0; i < nr; i++) begin
                if (!room_written[rm*ROUTERS + i]) begin
                    send_request(rfnr_pkg::OP_LOAD, rm, 0, i, $urandom_range(0, 255));
                end
            end
        end
        n_req = $urandom_range(40, 80);
        for (int k = 0; k < n_req; k++) begin
            if (k == 20) drain();
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                room = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROOMS - 1)
                                                   : $urandom_range(0, rooms_full - 1);
                send_request(rfnr_pkg::OP_LOAD, room, $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom_range(0, 255));
            end else if (pick < 37) begin
                room = $urandom_range(0, ROOMS - 1);
                if (!room_ready(room)) room = $urandom_range(0, rooms_full - 1);
                send_request(rfnr_pkg::OP_SEAL, room, $urandom_range(0, 15), 0, 0);
            end else if (pick < 67) begin
                send_request(rfnr_pkg::OP_SET, $urandom_range(0, 63),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 5),
                             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, nr - 1),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, 147) - 127);
            end else begin
                send_request(rfnr_pkg::OP_QUERY, $urandom_range(0, 63),
                             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 5),
                             $urandom_range(0, 15), $urandom_range(0, 255));
            end
        end
    endtask

    function automatic t_step_row req_row(logic [1:0] op, int room, int user, int router,
                                          int dbm, bit typed, logic [1:0] st);
        t_step_row row;
        row = '{is_cfg: 1'b0, addr: 1'b0, value: '0, op: op, room: room, user: user,
                router: router, dbm: dbm, typed: typed, res: '0};
        row.res.status = st;
        return row;
    endfunction

    function automatic t_step_row cfg_row(logic addr, logic [6:0] value);
        t_step_row row;
        row = req_row(rfnr_pkg::OP_LOAD, 0, 0, 0, 0, 1'b0, rfnr_pkg::ST_OK);
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.value  = value;
        return row;
    endfunction

    t_step_row directed [$];

    // result side: random stalls, checking against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                stall_left = stalls_on ? $urandom_range(0, 18) : 0;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result: tuser=%0d tdata=%h",
                                              o_m_axis_tuser, o_m_axis_tdata);
                end else begin
                    automatic t_locate_res want = expected_results.pop_front();
                    if (o_m_axis_tuser !== want.status || o_m_axis_tdata[5:0] !== want.room
                            || o_m_axis_tdata[27:6] !== want.distance
                            || o_m_axis_tdata[31:28] !== 4'd0) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: expected status=%0d room=%0d dist=%0d",
                                     want.status, want.room, want.distance);
                            $display("          actual   status=%0d room=%0d dist=%0d",
                                     o_m_axis_tuser, o_m_axis_tdata[5:0],
                                     o_m_axis_tdata[27:6]);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any request or result moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase;
        build_power_table();
        for (int i = 0; i < USERS*ROUTERS; i++) user_dbm[i] = rfnr_pkg::ABSENT_DBM;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unknown user, no rooms yet, range errors, saturation, absent marker,
        // unsealed room too far away, seal, zero-norm user, router count clamped
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 0, 0, 0, 1, rfnr_pkg::ST_NONE));
        directed.push_back(req_row(rfnr_pkg::OP_SET, 0, 0, 15, 20, 1, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 0, 0, 0, 1, rfnr_pkg::ST_NONE));
        directed.push_back(req_row(rfnr_pkg::OP_SET, 0, 1, 3, -128, 1, rfnr_pkg::ST_OK));
        directed.push_back(cfg_row(rfnr_pkg::CFG_ROUTERS, 7'd2));
        directed.push_back(req_row(rfnr_pkg::OP_LOAD, 0, 0, 2, 5, 1, rfnr_pkg::ST_RANGE));
        directed.push_back(req_row(rfnr_pkg::OP_SET, 0, 2, 9, -50, 1, rfnr_pkg::ST_RANGE));
        directed.push_back(req_row(rfnr_pkg::OP_LOAD, 0, 0, 0, 127, 1, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_LOAD, 0, 0, 1, -127, 1, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_LOAD, 63, 0, 0, -128, 1, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_LOAD, 63, 0, 1, 20, 1, rfnr_pkg::ST_OK));
        directed.push_back(cfg_row(rfnr_pkg::CFG_ROOMS, 7'd1));
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 0, 0, 0, 1, rfnr_pkg::ST_NONE));
        directed.push_back(req_row(rfnr_pkg::OP_SEAL, 0, 0, 0, 0, 1, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 0, 0, 0, 0, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_SET, 0, 0, 0, 20, 1, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 0, 0, 0, 0, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_SEAL, 63, 0, 0, 0, 1, rfnr_pkg::ST_OK));
        directed.push_back(cfg_row(rfnr_pkg::CFG_ROUTERS, 7'd0));
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 1, 0, 0, 0, rfnr_pkg::ST_OK));
        directed.push_back(req_row(rfnr_pkg::OP_SET, 0, 3, 1, 0, 1, rfnr_pkg::ST_RANGE));
        directed.push_back(req_row(rfnr_pkg::OP_QUERY, 0, 3, 0, 0, 1, rfnr_pkg::ST_NONE));

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                write_reg(directed[k].addr, directed[k].value);
            end else begin
                send_request(directed[k].op, directed[k].room, directed[k].user,
                             directed[k].router, directed[k].dbm,
                             directed[k].typed, directed[k].res);
            end
        end

        phase = 0;
        while (items_sent < ITEMS) begin
            run_phase(phase);
            phase++;
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fails == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- rssi_fingerprint_nearest_room_top.f -----
sv/rfnr_pkg.sv
sv/rssi_fingerprint_nearest_room_top.sv
bench/tb_top.sv
